// ===== design/jse_pkg.sv =====
// Shared types, constants and helpers for the JSON string escaper.
package jse_pkg;

    localparam int CP_W        = 21;
    localparam int CHAR_W      = 7;
    localparam int HALF_W      = 16;
    localparam int IDX_W       = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] KIND_PLAIN = 2'd0;
    localparam logic [1:0] KIND_PAIR  = 2'd1;
    localparam logic [1:0] KIND_U1    = 2'd2;
    localparam logic [1:0] KIND_U2    = 2'd3;

    localparam logic [CHAR_W-1:0] CH_BSLASH = 7'h5C;
    localparam logic [CHAR_W-1:0] CH_QUOTE  = 7'h22;
    localparam logic [CHAR_W-1:0] CH_U      = 7'h75;
    localparam logic [CHAR_W-1:0] CH_N      = 7'h6E;
    localparam logic [CHAR_W-1:0] CH_R      = 7'h72;
    localparam logic [CHAR_W-1:0] CH_T      = 7'h74;
    localparam logic [CHAR_W-1:0] CH_B      = 7'h62;
    localparam logic [CHAR_W-1:0] CH_F      = 7'h66;

    localparam logic [CP_W-1:0]   CP_SPACE  = 21'h00020;
    localparam logic [CP_W-1:0]   CP_TILDE  = 21'h0007E;
    localparam logic [CP_W-1:0]   CP_BMP    = 21'h0FFFF;
    localparam logic [CP_W-1:0]   CP_SUPP   = 21'h10000;
    localparam logic [HALF_W-1:0] SUR_HIGH  = 16'hD800;
    localparam logic [HALF_W-1:0] SUR_LOW   = 16'hDC00;

    typedef struct packed {
        logic [1:0]        kind;
        logic [CHAR_W-1:0] lit;
        logic [HALF_W-1:0] hi;
        logic [HALF_W-1:0] lo;
        logic              last;
    } jse_desc_t;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
        logic [CHAR_W-1:0] ext;
        ext = {3'b000, nib};
        if (nib < 4'd10)
        begin
            return 7'h30 + ext;
        end
        return 7'h57 + ext;
    endfunction

endpackage

// ===== design/jse_if.sv =====
// Channel interfaces: code point input and escaped byte output.
interface jse_cp_if import jse_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CP_W-1:0]   code_point;
    logic              string_last;

    modport source (output valid, output code_point, output string_last, input ready);
    modport sink   (input valid, input code_point, input string_last, output ready);
endinterface

interface jse_byte_if import jse_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              run_last;
    logic              string_end;

    modport source (output valid, output out_char, output run_last, output string_end,
                    input ready);
    modport sink   (input valid, input out_char, input run_last, input string_end,
                    output ready);
endinterface

// ===== design/json_string_escaper.sv =====
// Top level of the JSON string escaper.
// Takes one code point per beat on cp_chan and emits its JSON-escaped form as
// 1 to 12 ASCII bytes on byte_chan, one byte per beat, with run_last on the
// final byte of each character and string_end where that character closed
// the string. Output runs at one byte per cycle while byte_chan is ready, set
// by the single output register in the back end: printable ASCII flows at
// one character per cycle, while a two-character escape is 2 bytes, a \u
// escape 6 and a surrogate pair 12. A character's first byte is offered once
// it has passed the queue slot and the output register. It keeps its slot in
// the QUEUE_DEPTH-entry descriptor queue until its last byte is loaded into
// the output register, so up to QUEUE_DEPTH - 1 more characters are taken
// during a run before input stalls. No state survives between characters.
module json_string_escaper import jse_pkg::*;
#(
    parameter int QUEUE_DEPTH = jse_pkg::QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    jse_cp_if.sink     cp_chan,
    jse_byte_if.source byte_chan
);

    logic      push;
    logic      pop;
    logic      q_full;
    logic      q_not_empty;
    jse_desc_t push_desc;
    jse_desc_t head;

    jse_front u_front (
        .cp_chan (cp_chan),
        .q_full  (q_full),
        .push    (push),
        .desc    (push_desc)
    );

    jse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (head)
    );

    jse_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .head        (head),
        .pop         (pop),
        .byte_chan   (byte_chan)
    );

endmodule

// ===== design/jse_front.sv =====
// Front end: classify a code point into an escape descriptor.
module jse_front import jse_pkg::*;
(
    jse_cp_if.sink     cp_chan,
    input  logic       q_full,
    output logic       push,
    output jse_desc_t  desc
);

    logic [CP_W-1:0] cp;
    logic [CP_W-1:0] off;

    assign cp           = cp_chan.code_point;
    assign off          = cp - CP_SUPP;
    assign cp_chan.ready = !q_full;
    assign push         = cp_chan.valid && !q_full;

    always_comb
    begin
        desc.kind = KIND_PLAIN;
        desc.lit  = cp[CHAR_W-1:0];
        desc.hi   = cp[HALF_W-1:0];
        desc.lo   = SUR_LOW + {6'b000000, off[9:0]};
        desc.last = cp_chan.string_last;
        case (cp)
            21'h0005C:
            begin
                desc.kind = KIND_PAIR;
                desc.lit  = CH_BSLASH;
            end
            21'h00022:
            begin
                desc.kind = KIND_PAIR;
                desc.lit  = CH_QUOTE;
            end
            21'h0000A:
            begin
                desc.kind = KIND_PAIR;
                desc.lit  = CH_N;
            end
            21'h0000D:
            begin
                desc.kind = KIND_PAIR;
                desc.lit  = CH_R;
            end
            21'h00009:
            begin
                desc.kind = KIND_PAIR;
                desc.lit  = CH_T;
            end
            21'h00008:
            begin
                desc.kind = KIND_PAIR;
                desc.lit  = CH_B;
            end
            21'h0000C:
            begin
                desc.kind = KIND_PAIR;
                desc.lit  = CH_F;
            end
            default:
            begin
                if (cp < CP_SPACE)
                begin
                    desc.kind = KIND_U1;
                end
                else if (cp > CP_TILDE)
                begin
                    if (cp <= CP_BMP)
                    begin
                        desc.kind = KIND_U1;
                    end
                    else
                    begin
                        desc.kind = KIND_U2;
                        desc.hi   = SUR_HIGH + {5'b00000, off[20:10]};
                    end
                end
            end
        endcase
    end

endmodule

// ===== design/jse_queue.sv =====
// Short descriptor queue between the front and back ends.
module jse_queue import jse_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  jse_desc_t  push_desc,
    input  logic       pop,
    output logic       full,
    output logic       not_empty,
    output jse_desc_t  head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

    jse_desc_t        slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_MAX);
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// ===== design/jse_back.sv =====
// Back end: step through a descriptor and emit one escaped byte per beat.
module jse_back import jse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_not_empty,
    input  jse_desc_t   head,
    output logic        pop,
    jse_byte_if.source  byte_chan
);

    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              valid_reg, valid_next;
    logic [CHAR_W-1:0] char_reg;
    logic              run_last_reg;
    logic              string_end_reg;

    logic              load;
    logic              grp;
    logic [IDX_W-1:0]  pos;
    logic [HALF_W-1:0] val;
    logic [3:0]        nib;
    logic [CHAR_W-1:0] u_char;
    logic [CHAR_W-1:0] cur_char;
    logic [IDX_W-1:0]  end_idx;
    logic              is_end;

    assign load = q_not_empty && (!valid_reg || byte_chan.ready);
    assign grp  = (idx_reg >= 4'd6);
    assign pos  = grp ? idx_reg - 4'd6 : idx_reg;
    assign val  = grp ? head.lo : head.hi;

    always_comb
    begin
        case (pos)
            4'd2:    nib = val[15:12];
            4'd3:    nib = val[11:8];
            4'd4:    nib = val[7:4];
            default: nib = val[3:0];
        endcase
        case (pos)
            4'd0:    u_char = CH_BSLASH;
            4'd1:    u_char = CH_U;
            default: u_char = hex_char(nib);
        endcase
    end

    always_comb
    begin
        case (head.kind)
            KIND_PLAIN:
            begin
                cur_char = head.lit;
                end_idx  = 4'd0;
            end
            KIND_PAIR:
            begin
                cur_char = (idx_reg == '0) ? CH_BSLASH : head.lit;
                end_idx  = 4'd1;
            end
            KIND_U1:
            begin
                cur_char = u_char;
                end_idx  = 4'd5;
            end
            default:
            begin
                cur_char = u_char;
                end_idx  = 4'd11;
            end
        endcase
    end

    assign is_end = (idx_reg == end_idx);
    assign pop    = load && is_end;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = is_end ? '0 : idx_reg + 1'b1;
        end
        else if (byte_chan.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg       <= cur_char;
            run_last_reg   <= is_end;
            string_end_reg <= is_end && head.last;
        end
    end

    assign byte_chan.valid      = valid_reg;
    assign byte_chan.out_char   = char_reg;
    assign byte_chan.run_last   = run_last_reg;
    assign byte_chan.string_end = string_end_reg;

endmodule
